// ===== rtl/three_axis_homing_sequencer_unit_defines.svh =====
// assertion macros for the three-axis homing sequencer unit
// used by modules that assert; expects clk and rst_n in scope
`ifndef THREE_AXIS_HOMING_SEQUENCER_UNIT_DEFINES_SVH
`define THREE_AXIS_HOMING_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define THSU_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("thsu assertion failed");
`define THSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thsu assertion failed");
`else
`define THSU_ASSERT(lbl, cond)
`define THSU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/thsu_pkg.sv =====
// types, constants and command tables for the three-axis homing sequencer
// no dependencies
`timescale 1ns / 1ps

package thsu_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W = 32;
  localparam int CFG_W = 16;
  localparam int DEF_POSITION_WIDTH = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] APPROACH_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] CREEP_RESET = 16'd100;

  localparam logic CFG_APPROACH = 1'b0;
  localparam logic CFG_CREEP = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [VALUE_W-1:0] APPROACH_DIST_POS = 32'sd1000000;
  localparam logic signed [VALUE_W-1:0] APPROACH_DIST_NEG = -32'sd1000000;
  localparam logic signed [VALUE_W-1:0] CREEP_DIST_POS = 32'sd10000;
  localparam logic signed [VALUE_W-1:0] CREEP_DIST_NEG = -32'sd10000;
  localparam logic signed [VALUE_W-1:0] FINAL_VELOCITY = 32'sd100;

  typedef enum logic [2:0] {
    CMD_STATUS = 3'd0,
    CMD_SET_VEL = 3'd1,
    CMD_MOVE = 3'd2,
    CMD_STOP_ALL = 3'd3,
    CMD_ZERO_POS = 3'd4,
    CMD_CLEAR_SAFETY = 3'd5
  } cmd_code_t;

  // what one step hands to the back end
  typedef enum logic [2:0] {
    K_STATUS = 3'd0,
    K_STATUS_APPROACH = 3'd1,
    K_APPROACH = 3'd2,
    K_CREEP = 3'd3,
    K_STOP = 3'd4,
    K_FINISH = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    VS_ZERO = 3'd0,
    VS_APPROACH = 3'd1,
    VS_CREEP = 3'd2,
    VS_FINAL = 3'd3,
    VS_APPROACH_DIST = 3'd4,
    VS_CREEP_DIST = 3'd5
  } vsel_t;

  typedef struct packed {
    kind_t kind;
    logic [1:0] axis;
    logic homing;
    logic done;
    logic safety;
  } step_t;

  typedef struct packed {
    cmd_code_t code;
    vsel_t vsel;
    logic is_move;
    logic last;
  } cmd_info_t;

  function automatic cmd_info_t cmd_info(input kind_t kind, input logic [1:0] idx);
    cmd_info_t c;
    c = '{code: CMD_STATUS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b1};
    case (kind)
      K_STATUS: begin
        c = '{code: CMD_STATUS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b1};
      end
      K_STATUS_APPROACH: begin
        case (idx)
          2'd0: c = '{code: CMD_STATUS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b0};
          2'd1: c = '{code: CMD_SET_VEL, vsel: VS_APPROACH, is_move: 1'b0, last: 1'b0};
          default: c = '{code: CMD_MOVE, vsel: VS_APPROACH_DIST, is_move: 1'b1, last: 1'b1};
        endcase
      end
      K_APPROACH: begin
        if (idx == 2'd0) begin
          c = '{code: CMD_SET_VEL, vsel: VS_APPROACH, is_move: 1'b0, last: 1'b0};
        end else begin
          c = '{code: CMD_MOVE, vsel: VS_APPROACH_DIST, is_move: 1'b1, last: 1'b1};
        end
      end
      K_CREEP: begin
        if (idx == 2'd0) begin
          c = '{code: CMD_SET_VEL, vsel: VS_CREEP, is_move: 1'b0, last: 1'b0};
        end else begin
          c = '{code: CMD_MOVE, vsel: VS_CREEP_DIST, is_move: 1'b1, last: 1'b1};
        end
      end
      K_STOP: begin
        c = '{code: CMD_STOP_ALL, vsel: VS_ZERO, is_move: 1'b0, last: 1'b1};
      end
      K_FINISH: begin
        case (idx)
          2'd0: c = '{code: CMD_CLEAR_SAFETY, vsel: VS_ZERO, is_move: 1'b0, last: 1'b0};
          2'd1: c = '{code: CMD_STATUS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b0};
          2'd2: c = '{code: CMD_SET_VEL, vsel: VS_FINAL, is_move: 1'b0, last: 1'b0};
          default: c = '{code: CMD_ZERO_POS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b1};
        endcase
      end
      default: begin
        c = '{code: CMD_STATUS, vsel: VS_ZERO, is_move: 1'b0, last: 1'b1};
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/thsu_front.sv =====
// front end: accepts input items, runs the homing phase machine, classifies steps
// depends on thsu_pkg
`timescale 1ns / 1ps

module thsu_front #(
  parameter int LATCH_W = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_mode,
  input  logic in_sensor_x,
  input  logic in_sensor_y,
  input  logic in_sensor_z,
  input  logic in_axes_moving,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_z,
  input  logic q_full,
  output logic q_push,
  output thsu_pkg::step_t q_step,
  output logic [LATCH_W-1:0] q_lx,
  output logic [LATCH_W-1:0] q_ly,
  output logic [LATCH_W-1:0] q_lz
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_Z_START = 5'd1, PH_Z_WAIT_APP = 5'd2, PH_Z_CREEP = 5'd3,
    PH_Z_EDGE = 5'd4, PH_Z_STOP = 5'd5,
    PH_X_START = 5'd6, PH_X_WAIT_APP = 5'd7, PH_X_CREEP = 5'd8,
    PH_X_EDGE = 5'd9, PH_X_STOP = 5'd10,
    PH_Y_START = 5'd11, PH_Y_WAIT_APP = 5'd12, PH_Y_CREEP = 5'd13,
    PH_Y_EDGE = 5'd14, PH_Y_STOP = 5'd15,
    PH_FINISH = 5'd16
  } phase_t;

  typedef enum logic [2:0] {
    SUB_IDLE, SUB_START, SUB_WAIT_APP, SUB_CREEP, SUB_EDGE, SUB_STOP, SUB_FINISH
  } sub_t;

  phase_t phase_r, phase_nxt, ph;
  sub_t sub;
  logic [1:0] ax;
  logic sensor;
  logic [LATCH_W-1:0] pos_trunc;
  logic [LATCH_W-1:0] lx_r, ly_r, lz_r, lx_nxt, ly_nxt, lz_nxt;
  logic homing_r, done_r, safety_r, homing_nxt, done_nxt, safety_nxt;
  logic emit;
  thsu_pkg::kind_t kind;
  logic acc;

  assign in_stall = q_full;
  assign acc = in_valid && !in_stall;

  // a start request overrides whatever phase we were in
  assign ph = in_mode ? PH_Z_START : phase_r;

  always_comb begin
    ax = thsu_pkg::AXIS_Z;
    sub = SUB_IDLE;
    case (ph)
      PH_Z_START: begin sub = SUB_START; ax = thsu_pkg::AXIS_Z; end
      PH_Z_WAIT_APP: begin sub = SUB_WAIT_APP; ax = thsu_pkg::AXIS_Z; end
      PH_Z_CREEP: begin sub = SUB_CREEP; ax = thsu_pkg::AXIS_Z; end
      PH_Z_EDGE: begin sub = SUB_EDGE; ax = thsu_pkg::AXIS_Z; end
      PH_Z_STOP: begin sub = SUB_STOP; ax = thsu_pkg::AXIS_Z; end
      PH_X_START: begin sub = SUB_START; ax = thsu_pkg::AXIS_X; end
      PH_X_WAIT_APP: begin sub = SUB_WAIT_APP; ax = thsu_pkg::AXIS_X; end
      PH_X_CREEP: begin sub = SUB_CREEP; ax = thsu_pkg::AXIS_X; end
      PH_X_EDGE: begin sub = SUB_EDGE; ax = thsu_pkg::AXIS_X; end
      PH_X_STOP: begin sub = SUB_STOP; ax = thsu_pkg::AXIS_X; end
      PH_Y_START: begin sub = SUB_START; ax = thsu_pkg::AXIS_Y; end
      PH_Y_WAIT_APP: begin sub = SUB_WAIT_APP; ax = thsu_pkg::AXIS_Y; end
      PH_Y_CREEP: begin sub = SUB_CREEP; ax = thsu_pkg::AXIS_Y; end
      PH_Y_EDGE: begin sub = SUB_EDGE; ax = thsu_pkg::AXIS_Y; end
      PH_Y_STOP: begin sub = SUB_STOP; ax = thsu_pkg::AXIS_Y; end
      PH_FINISH: begin sub = SUB_FINISH; end
      default: begin sub = SUB_IDLE; end
    endcase
  end

  always_comb begin
    case (ax)
      thsu_pkg::AXIS_X: begin
        sensor = in_sensor_x;
        pos_trunc = in_pos_x[LATCH_W-1:0];
      end
      thsu_pkg::AXIS_Y: begin
        sensor = in_sensor_y;
        pos_trunc = in_pos_y[LATCH_W-1:0];
      end
      default: begin
        sensor = in_sensor_z;
        pos_trunc = in_pos_z[LATCH_W-1:0];
      end
    endcase
  end

  always_comb begin
    phase_nxt = ph;
    homing_nxt = homing_r;
    done_nxt = done_r;
    safety_nxt = safety_r;
    lx_nxt = lx_r;
    ly_nxt = ly_r;
    lz_nxt = lz_r;
    emit = 1'b0;
    kind = thsu_pkg::K_STATUS;
    if (ph == PH_Z_START) begin
      homing_nxt = 1'b1;
      done_nxt = 1'b0;
      safety_nxt = 1'b0;
    end
    case (sub)
      SUB_START: begin
        if (!sensor) begin
          emit = 1'b1;
          kind = (ph == PH_Z_START) ? thsu_pkg::K_STATUS_APPROACH : thsu_pkg::K_APPROACH;
          phase_nxt = phase_t'(ph + 5'd1);
        end else begin
          // already on the sensor: only the status report of a Z start goes out
          emit = (ph == PH_Z_START);
          kind = thsu_pkg::K_STATUS;
          phase_nxt = phase_t'(ph + 5'd2);
        end
      end
      SUB_WAIT_APP: begin
        if (!in_axes_moving) phase_nxt = phase_t'(ph + 5'd1);
      end
      SUB_CREEP: begin
        emit = 1'b1;
        kind = thsu_pkg::K_CREEP;
        phase_nxt = phase_t'(ph + 5'd1);
      end
      SUB_EDGE: begin
        if (!sensor) begin
          emit = 1'b1;
          kind = thsu_pkg::K_STOP;
          phase_nxt = phase_t'(ph + 5'd1);
          case (ax)
            thsu_pkg::AXIS_X: lx_nxt = pos_trunc;
            thsu_pkg::AXIS_Y: ly_nxt = pos_trunc;
            default: lz_nxt = pos_trunc;
          endcase
        end
      end
      SUB_STOP: begin
        if (!in_axes_moving) phase_nxt = phase_t'(ph + 5'd1);
      end
      SUB_FINISH: begin
        emit = 1'b1;
        kind = thsu_pkg::K_FINISH;
        homing_nxt = 1'b0;
        done_nxt = 1'b1;
        safety_nxt = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign q_push = acc && emit;
  assign q_step = '{kind: kind, axis: ax, homing: homing_nxt, done: done_nxt,
                    safety: safety_nxt};
  assign q_lx = lx_nxt;
  assign q_ly = ly_nxt;
  assign q_lz = lz_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      homing_r <= 1'b0;
      done_r <= 1'b0;
      safety_r <= 1'b1;
      lx_r <= '0;
      ly_r <= '0;
      lz_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      homing_r <= homing_nxt;
      done_r <= done_nxt;
      safety_r <= safety_nxt;
      lx_r <= lx_nxt;
      ly_r <= ly_nxt;
      lz_r <= lz_nxt;
    end
  end

endmodule

// ===== rtl/thsu_queue.sv =====
// short step queue between front and back end
// depends on thsu_pkg for nothing; generic width and depth
`timescale 1ns / 1ps

module thsu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [WIDTH-1:0] wdata,
  input  logic pop,
  output logic [WIDTH-1:0] rdata,
  output logic full,
  output logic not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/thsu_back.sv =====
// back end: expands queued steps into commands, one per cycle while the output is not stalled, into the output register
// depends on thsu_pkg and three_axis_homing_sequencer_unit_defines.svh
`timescale 1ns / 1ps
`include "three_axis_homing_sequencer_unit_defines.svh"

module thsu_back #(
  parameter int LATCH_W = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  thsu_pkg::step_t q_step,
  input  logic [LATCH_W-1:0] q_lx,
  input  logic [LATCH_W-1:0] q_ly,
  input  logic [LATCH_W-1:0] q_lz,
  output logic q_pop,
  input  logic [thsu_pkg::CFG_W-1:0] approach_vel,
  input  logic [thsu_pkg::CFG_W-1:0] creep_vel,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] out_command,
  output logic [1:0] out_axis,
  output logic signed [thsu_pkg::VALUE_W-1:0] out_value,
  output logic out_homing_active,
  output logic out_home_done,
  output logic out_safety_enabled,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_x,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_y,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_z,
  output logic out_last
);

  thsu_pkg::step_t cur_r;
  logic [LATCH_W-1:0] lx_r, ly_r, lz_r;
  logic [1:0] idx_r;
  logic busy_r;
  logic out_valid_r;
  logic load, emit_now;
  thsu_pkg::cmd_info_t c;
  logic signed [thsu_pkg::VALUE_W-1:0] value;
  logic is_z;

  assign load = !out_valid_r || !out_stall;
  assign emit_now = busy_r && load;
  assign c = thsu_pkg::cmd_info(cur_r.kind, idx_r);
  // the next step is fetched as the last command of the current one goes out
  assign q_pop = q_valid && (!busy_r || (emit_now && c.last));
  assign is_z = (cur_r.axis == thsu_pkg::AXIS_Z);

  always_comb begin
    case (c.vsel)
      thsu_pkg::VS_APPROACH: value = thsu_pkg::VALUE_W'(approach_vel);
      thsu_pkg::VS_CREEP: value = thsu_pkg::VALUE_W'(creep_vel);
      thsu_pkg::VS_FINAL: value = thsu_pkg::FINAL_VELOCITY;
      thsu_pkg::VS_APPROACH_DIST:
        value = is_z ? thsu_pkg::APPROACH_DIST_POS : thsu_pkg::APPROACH_DIST_NEG;
      thsu_pkg::VS_CREEP_DIST:
        value = is_z ? thsu_pkg::CREEP_DIST_NEG : thsu_pkg::CREEP_DIST_POS;
      default: value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r <= '0;
    end else if (emit_now) begin
      if (c.last) busy_r <= 1'b0;
      else idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_step;
      lx_r <= q_lx;
      ly_r <= q_ly;
      lz_r <= q_lz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_now) begin
      out_valid_r <= 1'b1;
    end else if (load) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_command <= c.code;
      out_axis <= c.is_move ? cur_r.axis : thsu_pkg::AXIS_X;
      out_value <= value;
      out_homing_active <= cur_r.homing;
      out_home_done <= cur_r.done;
      out_safety_enabled <= cur_r.safety;
      out_home_pos_x <= thsu_pkg::POS_W'($signed(lx_r));
      out_home_pos_y <= thsu_pkg::POS_W'($signed(ly_r));
      out_home_pos_z <= thsu_pkg::POS_W'($signed(lz_r));
      out_last <= c.last;
    end
  end

  assign out_valid = out_valid_r;

  `THSU_ASSERT(a_pop_needs_entry, !q_pop || q_valid)
  `THSU_ASSERT(a_more_after_nonlast, !(out_valid_r && !out_last) || busy_r)
  `THSU_ASSERT_NEXT(a_idle_after_last, emit_now && c.last && !q_valid, !busy_r)
  `THSU_ASSERT_NEXT(a_refetch_clears_idx, q_pop, busy_r && idx_r == 2'd0)

endmodule

// ===== rtl/three_axis_homing_sequencer_unit.sv =====
// an item's step goes into the step queue, then into the back end's step register, before its
// first command is in the output register; the front end accepts an item whenever the queue is
// not full, and the back end issues one command per cycle unless the output stalls; an item
// yields 0 to 4 commands; a two-entry step queue separates front and back end
// reset (synchronous, rst_n low): phase idle, latches zero, safety flag set,
// approach velocity 1000, creep velocity 100, queue and output empty
`timescale 1ns / 1ps

module three_axis_homing_sequencer_unit #(
  parameter int POSITION_WIDTH = thsu_pkg::DEF_POSITION_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [thsu_pkg::CFG_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_mode,
  input  logic in_sensor_x,
  input  logic in_sensor_y,
  input  logic in_sensor_z,
  input  logic in_axes_moving,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [thsu_pkg::POS_W-1:0] in_pos_z,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] out_command,
  output logic [1:0] out_axis,
  output logic signed [thsu_pkg::VALUE_W-1:0] out_value,
  output logic out_homing_active,
  output logic out_home_done,
  output logic out_safety_enabled,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_x,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_y,
  output logic signed [thsu_pkg::POS_W-1:0] out_home_pos_z,
  output logic out_last
);

  // latched positions never need more bits than the input counts carry
  localparam int LATCH_W = (POSITION_WIDTH < thsu_pkg::POS_W) ? POSITION_WIDTH
                                                              : thsu_pkg::POS_W;
  localparam int STEP_W = $bits(thsu_pkg::step_t);
  localparam int Q_W = STEP_W + 3 * LATCH_W;

  logic [thsu_pkg::CFG_W-1:0] approach_r, creep_r;
  logic q_full, q_push, q_pop, q_not_empty;
  thsu_pkg::step_t f_step, b_step;
  logic [LATCH_W-1:0] f_lx, f_ly, f_lz, b_lx, b_ly, b_lz;
  logic [Q_W-1:0] q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      approach_r <= thsu_pkg::APPROACH_RESET;
      creep_r <= thsu_pkg::CREEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        thsu_pkg::CFG_APPROACH: approach_r <= cfg_wdata;
        thsu_pkg::CFG_CREEP: creep_r <= cfg_wdata;
        default: approach_r <= approach_r;
      endcase
    end
  end

  thsu_front #(.LATCH_W(LATCH_W)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_sensor_x(in_sensor_x), .in_sensor_y(in_sensor_y),
    .in_sensor_z(in_sensor_z), .in_axes_moving(in_axes_moving),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .q_full(q_full), .q_push(q_push), .q_step(f_step),
    .q_lx(f_lx), .q_ly(f_ly), .q_lz(f_lz)
  );

  assign q_wdata = {f_step, f_lx, f_ly, f_lz};
  assign {b_step, b_lx, b_ly, b_lz} = q_rdata;

  thsu_queue #(.WIDTH(Q_W), .DEPTH(thsu_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata),
    .full(q_full), .not_empty(q_not_empty)
  );

  thsu_back #(.LATCH_W(LATCH_W)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_not_empty), .q_step(b_step),
    .q_lx(b_lx), .q_ly(b_ly), .q_lz(b_lz), .q_pop(q_pop),
    .approach_vel(approach_r), .creep_vel(creep_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_command(out_command), .out_axis(out_axis), .out_value(out_value),
    .out_homing_active(out_homing_active), .out_home_done(out_home_done),
    .out_safety_enabled(out_safety_enabled),
    .out_home_pos_x(out_home_pos_x), .out_home_pos_y(out_home_pos_y),
    .out_home_pos_z(out_home_pos_z), .out_last(out_last)
  );

endmodule

// ===== bench/tb_three_axis_homing_sequencer_unit.sv =====
// self-checking bench for the three-axis homing sequencer: directed homing runs,
// then random runs under several velocity settings, most with random stalls on both sides
// depends on thsu_pkg and three_axis_homing_sequencer_unit
`timescale 1ns / 1ps

module tb_three_axis_homing_sequencer_unit;

  // sequencer phases: idle, three axis blocks of five steps each, then finish
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_Z = 5'd1;
  localparam logic [4:0] PH_X = 5'd6;
  localparam logic [4:0] PH_Y = 5'd11;
  localparam logic [4:0] PH_FINISH = 5'd16;
  localparam logic [4:0] AX_START = 5'd0;
  localparam logic [4:0] AX_APPROACH_WAIT = 5'd1;
  localparam logic [4:0] AX_CREEP = 5'd2;
  localparam logic [4:0] AX_EDGE_WAIT = 5'd3;
  localparam logic [4:0] AX_SPAN = 5'd5;

  localparam int LATCH_W = thsu_pkg::DEF_POSITION_WIDTH;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 150;
  localparam int HOLD_AFTER = 60;
  localparam logic signed [thsu_pkg::POS_W-1:0] POS_MAX = 32'sh7fffffff;
  localparam logic signed [thsu_pkg::POS_W-1:0] POS_MIN = 32'sh80000000;

  typedef struct {
    logic mode;
    logic sensor_x;
    logic sensor_y;
    logic sensor_z;
    logic moving;
    logic signed [thsu_pkg::POS_W-1:0] pos_x;
    logic signed [thsu_pkg::POS_W-1:0] pos_y;
    logic signed [thsu_pkg::POS_W-1:0] pos_z;
  } tick_t;

  typedef struct {
    thsu_pkg::cmd_code_t command;
    logic [1:0] axis;
    logic signed [thsu_pkg::VALUE_W-1:0] value;
    logic homing;
    logic done;
    logic safety;
    logic signed [thsu_pkg::POS_W-1:0] hx;
    logic signed [thsu_pkg::POS_W-1:0] hy;
    logic signed [thsu_pkg::POS_W-1:0] hz;
    logic last;
  } cmd_rec_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = thsu_pkg::CFG_APPROACH;
  logic [thsu_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic in_sensor_x = 1'b0;
  logic in_sensor_y = 1'b0;
  logic in_sensor_z = 1'b0;
  logic in_axes_moving = 1'b0;
  logic signed [thsu_pkg::POS_W-1:0] in_pos_x = '0;
  logic signed [thsu_pkg::POS_W-1:0] in_pos_y = '0;
  logic signed [thsu_pkg::POS_W-1:0] in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] out_command;
  logic [1:0] out_axis;
  logic signed [thsu_pkg::VALUE_W-1:0] out_value;
  logic out_homing_active;
  logic out_home_done;
  logic out_safety_enabled;
  logic signed [thsu_pkg::POS_W-1:0] out_home_pos_x;
  logic signed [thsu_pkg::POS_W-1:0] out_home_pos_y;
  logic signed [thsu_pkg::POS_W-1:0] out_home_pos_z;
  logic out_last;

  three_axis_homing_sequencer_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_sensor_x(in_sensor_x),
    .in_sensor_y(in_sensor_y),
    .in_sensor_z(in_sensor_z),
    .in_axes_moving(in_axes_moving),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_command(out_command),
    .out_axis(out_axis),
    .out_value(out_value),
    .out_homing_active(out_homing_active),
    .out_home_done(out_home_done),
    .out_safety_enabled(out_safety_enabled),
    .out_home_pos_x(out_home_pos_x),
    .out_home_pos_y(out_home_pos_y),
    .out_home_pos_z(out_home_pos_z),
    .out_last(out_last)
  );

  tick_t tick_q[$];
  cmd_rec_t cmd_expect_q[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 1'b0;
  logic in_fired = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  // sequencer shadow state and register copies
  logic [4:0] seq_phase;
  logic signed [thsu_pkg::POS_W-1:0] home_x, home_y, home_z;
  logic homing_f, done_f, safety_f;
  logic [thsu_pkg::CFG_W-1:0] approach_vel, creep_vel;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [thsu_pkg::POS_W-1:0] rand_pos();
    case ($urandom_range(0, 11))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tick_t tk(input logic m, input logic sx, input logic sy, input logic sz,
                               input logic mv, input logic signed [thsu_pkg::POS_W-1:0] px,
                               input logic signed [thsu_pkg::POS_W-1:0] py,
                               input logic signed [thsu_pkg::POS_W-1:0] pz);
    tick_t t;
    t = '{m, sx, sy, sz, mv, px, py, pz};
    return t;
  endfunction

  // noisy ticks are fully random; others bias the sensors and motion so runs progress
  function automatic tick_t mk_tick(input bit start, input bit noisy);
    tick_t t;
    if (noisy) begin
      t = tk(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
             rand_pos(), rand_pos(), rand_pos());
    end else begin
      t = tk(start || ($urandom_range(0, 39) == 0), $urandom_range(0, 99) < 45,
             $urandom_range(0, 99) < 45, $urandom_range(0, 99) < 45,
             $urandom_range(0, 99) < 35, rand_pos(), rand_pos(), rand_pos());
    end
    return t;
  endfunction

  function automatic cmd_rec_t mk_cmd(input thsu_pkg::cmd_code_t code, input logic [1:0] ax,
                                      input logic signed [thsu_pkg::VALUE_W-1:0] val);
    cmd_rec_t c;
    c.command = code;
    c.axis = ax;
    c.value = val;
    c.homing = 1'b0;
    c.done = 1'b0;
    c.safety = 1'b0;
    c.hx = '0;
    c.hy = '0;
    c.hz = '0;
    c.last = 1'b0;
    return c;
  endfunction

  // advances the shadow sequencer by one tick and queues the commands it issues
  task automatic home_seq_predict(input tick_t t);
    cmd_rec_t step_cmds[$];
    logic [4:0] base;
    logic sensor;
    logic [1:0] ax;
    logic signed [thsu_pkg::VALUE_W-1:0] far_dist, back_dist;
    logic signed [thsu_pkg::POS_W-1:0] pos, lat;
    logic signed [thsu_pkg::VALUE_W-1:0] v_app, v_creep;
    base = PH_Z;
    sensor = t.sensor_z;
    ax = thsu_pkg::AXIS_Z;
    far_dist = thsu_pkg::APPROACH_DIST_POS;
    back_dist = thsu_pkg::CREEP_DIST_NEG;
    pos = t.pos_z;
    v_app = $signed({{(thsu_pkg::VALUE_W-thsu_pkg::CFG_W){1'b0}}, approach_vel});
    v_creep = $signed({{(thsu_pkg::VALUE_W-thsu_pkg::CFG_W){1'b0}}, creep_vel});

    if (t.mode) seq_phase = PH_Z;
    if (seq_phase == PH_Z) begin
      safety_f = 1'b0;
      homing_f = 1'b1;
      done_f = 1'b0;
      step_cmds.push_back(mk_cmd(thsu_pkg::CMD_STATUS, '0, '0));
    end

    if (seq_phase >= PH_X && seq_phase < PH_Y) begin
      base = PH_X;
      sensor = t.sensor_x;
      ax = thsu_pkg::AXIS_X;
      far_dist = thsu_pkg::APPROACH_DIST_NEG;
      back_dist = thsu_pkg::CREEP_DIST_POS;
      pos = t.pos_x;
    end else if (seq_phase >= PH_Y && seq_phase < PH_FINISH) begin
      base = PH_Y;
      sensor = t.sensor_y;
      ax = thsu_pkg::AXIS_Y;
      far_dist = thsu_pkg::APPROACH_DIST_NEG;
      back_dist = thsu_pkg::CREEP_DIST_POS;
      pos = t.pos_y;
    end

    if (seq_phase >= PH_Z && seq_phase < PH_FINISH) begin
      case (seq_phase - base)
        AX_START: begin
          if (!sensor) begin
            step_cmds.push_back(mk_cmd(thsu_pkg::CMD_SET_VEL, '0, v_app));
            step_cmds.push_back(mk_cmd(thsu_pkg::CMD_MOVE, ax, far_dist));
            seq_phase = base + AX_APPROACH_WAIT;
          end else begin
            // sensor already on: skip the approach
            seq_phase = base + AX_CREEP;
          end
        end
        AX_APPROACH_WAIT: begin
          if (!t.moving) seq_phase = base + AX_CREEP;
        end
        AX_CREEP: begin
          step_cmds.push_back(mk_cmd(thsu_pkg::CMD_SET_VEL, '0, v_creep));
          step_cmds.push_back(mk_cmd(thsu_pkg::CMD_MOVE, ax, back_dist));
          seq_phase = base + AX_EDGE_WAIT;
        end
        AX_EDGE_WAIT: begin
          if (!sensor) begin
            lat = pos;
            if (LATCH_W < thsu_pkg::POS_W) begin
              lat = (pos <<< (thsu_pkg::POS_W - LATCH_W)) >>> (thsu_pkg::POS_W - LATCH_W);
            end
            case (ax)
              thsu_pkg::AXIS_X: home_x = lat;
              thsu_pkg::AXIS_Y: home_y = lat;
              default: home_z = lat;
            endcase
            step_cmds.push_back(mk_cmd(thsu_pkg::CMD_STOP_ALL, '0, '0));
            seq_phase = base + AX_EDGE_WAIT + 5'd1;
          end
        end
        default: begin
          // waiting for the stop; next axis block or finish follows
          if (!t.moving) seq_phase = base + AX_SPAN;
        end
      endcase
    end else if (seq_phase == PH_FINISH) begin
      safety_f = 1'b1;
      homing_f = 1'b0;
      done_f = 1'b1;
      seq_phase = PH_IDLE;
      step_cmds.push_back(mk_cmd(thsu_pkg::CMD_CLEAR_SAFETY, '0, '0));
      step_cmds.push_back(mk_cmd(thsu_pkg::CMD_STATUS, '0, '0));
      step_cmds.push_back(mk_cmd(thsu_pkg::CMD_SET_VEL, '0, thsu_pkg::FINAL_VELOCITY));
      step_cmds.push_back(mk_cmd(thsu_pkg::CMD_ZERO_POS, '0, '0));
    end else begin
      seq_phase = PH_IDLE;
    end

    foreach (step_cmds[k]) begin
      step_cmds[k].homing = homing_f;
      step_cmds[k].done = done_f;
      step_cmds[k].safety = safety_f;
      step_cmds[k].hx = home_x;
      step_cmds[k].hy = home_y;
      step_cmds[k].hz = home_z;
      step_cmds[k].last = (k == step_cmds.size() - 1);
      cmd_expect_q.push_back(step_cmds[k]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string fld, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", fld, got, want));
  endtask

  // input side: note each transfer and predict from the payload it carried
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        home_seq_predict(tk(in_mode, in_sensor_x, in_sensor_y, in_sensor_z, in_axes_moving,
                            in_pos_x, in_pos_y, in_pos_z));
      end
    end
  end

  always @(negedge clk) begin : drive_ticks
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_fired || !in_valid) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (tick_q.size() > 0) begin
        t = tick_q.pop_front();
        in_mode <= t.mode;
        in_sensor_x <= t.sensor_x;
        in_sensor_y <= t.sensor_y;
        in_sensor_z <= t.sensor_z;
        in_axes_moving <= t.moving;
        in_pos_x <= t.pos_x;
        in_pos_y <= t.pos_y;
        in_pos_z <= t.pos_z;
        in_valid <= 1'b1;
        in_gap = quiet ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall; one long hold lets the step queue fill while ticks keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!held_once && results_seen >= HOLD_AFTER) begin
      held_once = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else begin
      out_stall <= 1'b0;
      out_gap = quiet ? 0 : idle_len();
    end
  end

  always @(posedge clk) begin : check_results
    cmd_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (cmd_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected command %0d", out_command));
      end else begin
        want = cmd_expect_q.pop_front();
        check_field("command", 32'(out_command), 32'(want.command));
        check_field("axis", 32'(out_axis), 32'(want.axis));
        check_field("value", out_value, want.value);
        check_field("homing_active", 32'(out_homing_active), 32'(want.homing));
        check_field("home_done", 32'(out_home_done), 32'(want.done));
        check_field("safety_enabled", 32'(out_safety_enabled), 32'(want.safety));
        check_field("home_pos_x", out_home_pos_x, want.hx);
        check_field("home_pos_y", out_home_pos_y, want.hy);
        check_field("home_pos_z", out_home_pos_z, want.hz);
        check_field("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [thsu_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == thsu_pkg::CFG_APPROACH) approach_vel = val;
    else creep_vel = val;
  endtask

  // zero-command ticks leave no trace, so keep settling after everything has drained
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || cmd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_runs(input int count);
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        tick_q.push_back(mk_tick(1'b0, 1'b1));
        made++;
      end else begin
        tick_q.push_back(mk_tick(1'b1, 1'b0));
        made++;
        repeat ($urandom_range(15, 35)) begin
          tick_q.push_back(mk_tick(1'b0, 1'b0));
          made++;
        end
      end
    end
  endtask

  task automatic run_setting(input logic [thsu_pkg::CFG_W-1:0] app,
                             input logic [thsu_pkg::CFG_W-1:0] crp,
                             input bit calm, input int count);
    write_reg(thsu_pkg::CFG_APPROACH, app);
    write_reg(thsu_pkg::CFG_CREEP, crp);
    quiet = calm;
    queue_runs(count);
    drain();
  endtask

  initial begin
    seq_phase = PH_IDLE;
    home_x = '0;
    home_y = '0;
    home_z = '0;
    homing_f = 1'b0;
    done_f = 1'b0;
    safety_f = 1'b1;
    approach_vel = thsu_pkg::APPROACH_RESET;
    creep_vel = thsu_pkg::CREEP_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full run at reset velocities: Z approached, X found on its sensor, Y approached
    tick_q.push_back(tk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, POS_MAX, POS_MIN, -1));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    tick_q.push_back(tk(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 5, 6, 7));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1, 2, 3));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1, 2, 3));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1, 2, 3));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1, 2, 3));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, POS_MAX, POS_MAX, POS_MIN));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 9, 9, 9));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 9, 9, 9));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 9, 9, 9));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 9, 9, 9));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, POS_MAX, POS_MIN, POS_MIN));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4, 4, 4));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 4, 4, 4));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4, 4, 4));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 4, 4, 4));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, POS_MIN, -1, POS_MAX));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8, 8, 8));
    tick_q.push_back(tk(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8, 8, 8));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8, 8, 8));
    // start with Z already on its sensor, then restart while homing
    tick_q.push_back(tk(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2, 2, 2));
    tick_q.push_back(tk(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 3, 3, 3));
    tick_q.push_back(tk(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3, 3, 3));
    drain();

    run_setting('0, '1, 1'b0, 65);
    run_setting('1, '0, 1'b1, 65);
    run_setting(thsu_pkg::CFG_W'($urandom), thsu_pkg::CFG_W'($urandom), 1'b0, 65);
    run_setting(thsu_pkg::CFG_W'($urandom), thsu_pkg::CFG_W'($urandom), 1'b0, 65);

    if (errors == 0 && cmd_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
